/* design/iso_date_properties_unit_assert.svh */
// Assertion macros for the date properties unit.
`ifndef ISO_DATE_PROPERTIES_UNIT_ASSERT_SVH
`define ISO_DATE_PROPERTIES_UNIT_ASSERT_SVH

`ifndef SYNTH
`define IDP_ASSERT_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define IDP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define IDP_ASSERT_SAME(lbl, clk, rst, ante, cons)
`define IDP_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

/* design/idp_pkg.sv */
package idp_pkg;

  localparam logic [13:0] YEAR_MIN = 14'd1;
  localparam logic [13:0] YEAR_MAX = 14'd9999;

  localparam logic [3:0] MONTH_JAN = 4'd1;
  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [3:0] MONTH_MAR = 4'd3;
  localparam logic [3:0] MONTH_DEC = 4'd12;

  localparam int DIV100_MUL   = 5243;
  localparam int DIV100_SHIFT = 19;
  localparam int DIV7_MUL     = 2341;
  localparam int DIV7_SHIFT   = 14;

  localparam logic [9:0] GAUSS_BIAS = 10'd203;

  localparam logic [2:0] WD_FRIDAY   = 3'd5;
  localparam logic [2:0] WD_SATURDAY = 3'd6;
  localparam logic [2:0] WD_SUNDAY   = 3'd7;

  localparam logic [5:0] WEEK_FIRST = 6'd1;
  localparam logic [5:0] WEEK_SHORT = 6'd52;
  localparam logic [5:0] WEEK_LONG  = 6'd53;

  localparam logic [8:0] YEAR_DAYS = 9'd365;

  typedef struct packed {
    logic       leap;
    logic       prev_leap;
    logic       bad;
    logic [4:0] mlen;
    logic [4:0] day;
    logic [4:0] mterm;
    logic [8:0] dbefore;
    logic       after_feb;
    logic [6:0] cent;
    logic [6:0] yr;
    logic [6:0] jcent;
    logic [6:0] jyr;
  } front_t;

  typedef struct packed {
    logic       leap;
    logic       prev_leap;
    logic       bad;
    logic [4:0] mlen;
    logic [8:0] doy;
    logic [2:0] wd;
    logic [2:0] jan_wd;
    logic [8:0] num;
  } mid_t;

  function automatic logic [4:0] month_base_len(input logic [3:0] m);
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: month_base_len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    month_base_len = 5'd30;
      4'd2:                                       month_base_len = 5'd28;
      default:                                    month_base_len = 5'd0;
    endcase
  endfunction

  function automatic logic [8:0] days_before(input logic [3:0] m);
    case (m)
      4'd1:    days_before = 9'd0;
      4'd2:    days_before = 9'd31;
      4'd3:    days_before = 9'd59;
      4'd4:    days_before = 9'd90;
      4'd5:    days_before = 9'd120;
      4'd6:    days_before = 9'd151;
      4'd7:    days_before = 9'd181;
      4'd8:    days_before = 9'd212;
      4'd9:    days_before = 9'd243;
      4'd10:   days_before = 9'd273;
      4'd11:   days_before = 9'd304;
      4'd12:   days_before = 9'd334;
      default: days_before = 9'd0;
    endcase
  endfunction

  // (13 * m - 1) / 5 on the March-based month
  function automatic logic [4:0] month_term(input logic [3:0] m);
    case (m)
      4'd1:    month_term = 5'd28;
      4'd2:    month_term = 5'd31;
      4'd3:    month_term = 5'd2;
      4'd4:    month_term = 5'd5;
      4'd5:    month_term = 5'd7;
      4'd6:    month_term = 5'd10;
      4'd7:    month_term = 5'd12;
      4'd8:    month_term = 5'd15;
      4'd9:    month_term = 5'd18;
      4'd10:   month_term = 5'd20;
      4'd11:   month_term = 5'd23;
      4'd12:   month_term = 5'd25;
      default: month_term = 5'd0;
    endcase
  endfunction

endpackage

/* design/iso_date_properties_unit.sv */
// Calendar properties of one Gregorian date: leap flag, year and month length, ISO weekday,
// day of year and ISO-8601 week. A date is taken on every clock at which start is high;
// busy stays low, so one date per cycle is sustained. Each result appears six cycles after
// its date, for one cycle only, marked by done, and the receiver must take it then. The
// six register stages are year clamp and divide by 100, calendar decode, weekday sums,
// modulo 7, week divide, week correction. Years outside 1..9999 are clamped;
// a bad month or day gives bad_date with all other fields zero.
`include "iso_date_properties_unit_assert.svh"

module iso_date_properties_unit import idp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [13:0] year,
  input  logic [3:0]  month,
  input  logic [4:0]  day,
  output logic        done,
  output logic        leap,
  output logic [8:0]  year_length,
  output logic [4:0]  month_days,
  output logic [2:0]  weekday,
  output logic [8:0]  ordinal_day,
  output logic [5:0]  week_number,
  output logic        bad_date
);

  logic   front_valid;
  front_t front_data;
  logic   mid_valid;
  mid_t   mid_data;

  assign busy = 1'b0;

  idp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (start && !busy),
    .year      (year),
    .month     (month),
    .day       (day),
    .out_valid (front_valid),
    .out_data  (front_data)
  );

  idp_weekday u_weekday (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (front_valid),
    .in_data   (front_data),
    .out_valid (mid_valid),
    .out_data  (mid_data)
  );

  idp_week u_week (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (mid_valid),
    .in_data     (mid_data),
    .done        (done),
    .leap        (leap),
    .year_length (year_length),
    .month_days  (month_days),
    .weekday     (weekday),
    .ordinal_day (ordinal_day),
    .week_number (week_number),
    .bad_date    (bad_date)
  );

  `IDP_ASSERT_SAME(a_latency, clk, rst, done, $past(start && !busy, 6))
  `IDP_ASSERT_SAME(a_bad_zero, clk, rst, done && bad_date, (weekday == 3'd0) && (week_number == 6'd0) && (ordinal_day == 9'd0) && !leap)
  `IDP_ASSERT_SAME(a_good_fields, clk, rst, done && !bad_date, (weekday != 3'd0) && (week_number != 6'd0) && (leap == (year_length == 9'd366)))
  `IDP_ASSERT_NEXT(a_beat_flow, clk, rst, $past(start && !busy && !rst, 5), done)

endmodule

/* design/idp_front.sv */
module idp_front import idp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic [13:0] year,
  input  logic [3:0]  month,
  input  logic [4:0]  day,
  output logic        out_valid,
  output front_t      out_data
);

  logic        v1;
  logic [13:0] y1;
  logic [3:0]  m1;
  logic [4:0]  d1;
  logic [6:0]  q1;

  logic [13:0] yc;
  logic [26:0] prod;

  logic [13:0] rdiff;
  logic [6:0]  r;
  logic [6:0]  rp;
  logic [6:0]  qp;
  logic [13:0] yp;
  logic        leap;
  logic        prev_leap;
  logic        early;
  logic [4:0]  mlen;
  logic        bad;
  front_t      data_next;

  always_comb begin
    if (year < YEAR_MIN) begin
      yc = YEAR_MIN;
    end else if (year > YEAR_MAX) begin
      yc = YEAR_MAX;
    end else begin
      yc = year;
    end
    prod = 27'(yc) * 27'(DIV100_MUL);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1        <= in_valid;
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    y1 <= yc;
    m1 <= month;
    d1 <= day;
    q1 <= prod[DIV100_SHIFT+6:DIV100_SHIFT];
  end

  always_comb begin
    rdiff     = y1 - 14'(q1) * 14'd100;
    r         = rdiff[6:0];
    yp        = y1 - 14'd1;
    rp        = (r == 7'd0) ? 7'd99 : r - 7'd1;
    qp        = (r == 7'd0) ? q1 - 7'd1 : q1;
    leap      = (y1[1:0] == 2'd0) && ((r != 7'd0) || (q1[1:0] == 2'd0));
    prev_leap = (yp[1:0] == 2'd0) && ((rp != 7'd0) || (qp[1:0] == 2'd0));
    early     = m1 < MONTH_MAR;
    mlen      = month_base_len(m1) + 5'((m1 == MONTH_FEB) && leap);
    bad       = (m1 < MONTH_JAN) || (m1 > MONTH_DEC) || (d1 == 5'd0) || (d1 > mlen);

    data_next.leap      = leap;
    data_next.prev_leap = prev_leap;
    data_next.bad       = bad;
    data_next.mlen      = mlen;
    data_next.day       = d1;
    data_next.mterm     = month_term(m1);
    data_next.dbefore   = days_before(m1);
    data_next.after_feb = m1 > MONTH_FEB;
    data_next.cent      = early ? qp : q1;
    data_next.yr        = early ? rp : r;
    data_next.jcent     = qp;
    data_next.jyr       = rp;
  end

  always_ff @(posedge clk) begin
    out_data <= data_next;
  end

endmodule

/* design/idp_weekday.sv */
module idp_weekday import idp_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  input  front_t in_data,
  output logic   out_valid,
  output mid_t   out_data
);

  logic       v3;
  logic       leap3;
  logic       prev_leap3;
  logic       bad3;
  logic [4:0] mlen3;
  logic [8:0] sum3;
  logic [8:0] jsum3;
  logic [8:0] doy3;

  logic [9:0] sum_next;
  logic [9:0] jsum_next;
  logic [8:0] doy_next;
  logic [2:0] wd;
  logic [9:0] num;
  mid_t       data_next;

  function automatic logic [2:0] wd_of(input logic [8:0] s);
    logic [4:0] f1;
    logic [3:0] f2;
    logic [2:0] f3;
    f1 = 5'(s[8:6]) + 5'(s[5:3]) + 5'(s[2:0]);
    f2 = 4'(f1[4:3]) + 4'(f1[2:0]);
    f3 = 3'(f2[3]) + f2[2:0];
    return ((f3 == 3'd0) || (f3 == 3'd7)) ? WD_SUNDAY : f3;
  endfunction

  always_comb begin
    sum_next  = 10'(in_data.day) + 10'(in_data.mterm) + 10'(in_data.yr)
              + 10'(in_data.yr[6:2]) + 10'(in_data.cent[6:2]) + GAUSS_BIAS
              - {2'b00, in_data.cent, 1'b0};
    jsum_next = 10'd1 + 10'(month_term(MONTH_JAN)) + 10'(in_data.jyr)
              + 10'(in_data.jyr[6:2]) + 10'(in_data.jcent[6:2]) + GAUSS_BIAS
              - {2'b00, in_data.jcent, 1'b0};
    doy_next  = in_data.dbefore + 9'(in_data.day)
              + 9'(in_data.after_feb && in_data.leap);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v3        <= in_valid;
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    leap3      <= in_data.leap;
    prev_leap3 <= in_data.prev_leap;
    bad3       <= in_data.bad;
    mlen3      <= in_data.mlen;
    sum3       <= sum_next[8:0];
    jsum3      <= jsum_next[8:0];
    doy3       <= doy_next;
  end

  always_comb begin
    wd  = wd_of(sum3);
    num = 10'(doy3) + 10'd10 - 10'(wd);

    data_next.leap      = leap3;
    data_next.prev_leap = prev_leap3;
    data_next.bad       = bad3;
    data_next.mlen      = mlen3;
    data_next.doy       = doy3;
    data_next.wd        = wd;
    data_next.jan_wd    = wd_of(jsum3);
    data_next.num       = num[8:0];
  end

  always_ff @(posedge clk) begin
    out_data <= data_next;
  end

endmodule

/* design/idp_week.sv */
module idp_week import idp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  mid_t       in_data,
  output logic       done,
  output logic       leap,
  output logic [8:0] year_length,
  output logic [4:0] month_days,
  output logic [2:0] weekday,
  output logic [8:0] ordinal_day,
  output logic [5:0] week_number,
  output logic       bad_date
);

  logic       v5;
  mid_t       d5;
  logic [5:0] raw5;

  logic [20:0] prod;
  logic [8:0]  ylen;
  logic [5:0]  week;

  assign prod = 21'(in_data.num) * 21'(DIV7_MUL);

  always_ff @(posedge clk) begin
    if (rst) begin
      v5   <= 1'b0;
      done <= 1'b0;
    end else begin
      v5   <= in_valid;
      done <= v5;
    end
  end

  always_ff @(posedge clk) begin
    d5   <= in_data;
    raw5 <= prod[DIV7_SHIFT+5:DIV7_SHIFT];
  end

  always_comb begin
    ylen = YEAR_DAYS + 9'(d5.leap);
    week = raw5;
    if (raw5 == 6'd0) begin
      week = ((d5.jan_wd == WD_FRIDAY) || (d5.prev_leap && (d5.jan_wd == WD_SATURDAY)))
           ? WEEK_LONG : WEEK_SHORT;
    end else if ((raw5 == WEEK_LONG)
                 && ((10'(ylen) + 10'(d5.wd)) < (10'(d5.doy) + 10'd4))) begin
      week = WEEK_FIRST;
    end
  end

  always_ff @(posedge clk) begin
    if (d5.bad) begin
      leap        <= 1'b0;
      year_length <= 9'd0;
      month_days  <= 5'd0;
      weekday     <= 3'd0;
      ordinal_day <= 9'd0;
      week_number <= 6'd0;
      bad_date    <= 1'b1;
    end else begin
      leap        <= d5.leap;
      year_length <= ylen;
      month_days  <= d5.mlen;
      weekday     <= d5.wd;
      ordinal_day <= d5.doy;
      week_number <= week;
      bad_date    <= 1'b0;
    end
  end

endmodule

/* tb/iso_date_properties_unit_tb.sv */
`timescale 1ns / 100ps

module iso_date_properties_unit_tb;
  import idp_pkg::*;

  localparam int IDLE_PCT   = 33;
  localparam int STALL_MAX  = 2000;
  localparam int DRAIN_CYC  = 12;
  localparam int RAND_DATES = 1080;

  typedef struct packed {
    logic       leap;
    logic [8:0] year_length;
    logic [4:0] month_days;
    logic [2:0] weekday;
    logic [8:0] ordinal_day;
    logic [5:0] week_number;
    logic       bad_date;
  } date_props_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [13:0] year = '0;
  logic [3:0]  month = '0;
  logic [4:0]  day = '0;
  logic        busy;
  logic        done;
  logic        leap;
  logic [8:0]  year_length;
  logic [4:0]  month_days;
  logic [2:0]  weekday;
  logic [8:0]  ordinal_day;
  logic [5:0]  week_number;
  logic        bad_date;

  date_props_t props_due[$];
  bit          idle_en = 1'b1;
  int          fail_count = 0;
  int          stall_cycles = 0;

  iso_date_properties_unit u_top (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .year        (year),
    .month       (month),
    .day         (day),
    .done        (done),
    .leap        (leap),
    .year_length (year_length),
    .month_days  (month_days),
    .weekday     (weekday),
    .ordinal_day (ordinal_day),
    .week_number (week_number),
    .bad_date    (bad_date)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic bit is_leap_year(int unsigned y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  function automatic int unsigned days_in_month(int unsigned y, int unsigned m);
    if (m == MONTH_FEB)
      return 28 + is_leap_year(y);
    return 30 + ((m + m / 8) % 2);
  endfunction

  // Gauss's rule on a March-based year; 1 Monday .. 7 Sunday
  function automatic int unsigned iso_weekday(int unsigned y, int unsigned m, int unsigned d);
    int unsigned shift_m;
    int unsigned shift_y;
    int unsigned cent;
    int unsigned yy;
    int unsigned total;
    shift_m = (m < MONTH_MAR) ? m + 10 : m - 2;
    shift_y = (m < MONTH_MAR) ? y - 1 : y;
    cent    = shift_y / 100;
    yy      = shift_y % 100;
    total   = d + (13 * shift_m - 1) / 5 + yy + yy / 4 + cent / 4 + GAUSS_BIAS - 2 * cent;
    return (total % 7 == 0) ? WD_SUNDAY : total % 7;
  endfunction

  function automatic date_props_t calendar_props(logic [13:0] y_in, logic [3:0] m_in,
                                                 logic [4:0] d_in);
    date_props_t p;
    int unsigned y;
    int unsigned m;
    int unsigned d;
    int unsigned mlen;
    int unsigned doy;
    int unsigned wd;
    int unsigned jan1;
    int          wk;
    p = '0;
    y = y_in;
    m = m_in;
    d = d_in;
    if (y < YEAR_MIN) y = YEAR_MIN;
    if (y > YEAR_MAX) y = YEAR_MAX;
    if (m < MONTH_JAN || m > MONTH_DEC) begin
      p.bad_date = 1'b1;
      return p;
    end
    mlen = days_in_month(y, m);
    if (d < 1 || d > mlen) begin
      p.bad_date = 1'b1;
      return p;
    end
    wd  = iso_weekday(y, m, d);
    doy = d + ((m > MONTH_FEB) ? is_leap_year(y) : 0);
    for (int unsigned i = MONTH_JAN; i < m; i++)
      doy += days_in_month(1, i);
    wk = (doy + 10 - wd) / 7;
    if (wk < 1) begin
      jan1 = iso_weekday(y, MONTH_JAN, 1);
      wk = (jan1 == WD_FRIDAY || (is_leap_year(y - 1) && jan1 == WD_SATURDAY)) ?
           WEEK_LONG : WEEK_SHORT;
    end else if (wk == WEEK_LONG) begin
      if (int'(YEAR_DAYS + is_leap_year(y)) - int'(doy) < 4 - int'(wd))
        wk = WEEK_FIRST;
    end
    p.leap        = is_leap_year(y);
    p.year_length = YEAR_DAYS + 9'(is_leap_year(y));
    p.month_days  = 5'(mlen);
    p.weekday     = 3'(wd);
    p.ordinal_day = 9'(doy);
    p.week_number = 6'(wk);
    return p;
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endtask

  // record accepted dates, check result beats, watch for a hang
  always @(posedge clk) begin
    date_props_t want;
    if (!rst) begin
      if (done || (start && !busy))
        stall_cycles <= 0;
      else
        stall_cycles <= stall_cycles + 1;
      if (done) begin
        if (props_due.size() == 0) begin
          $error("result beat with no date outstanding");
          fail_count++;
        end else begin
          want = props_due.pop_front();
          check_field("leap", want.leap, leap);
          check_field("year_length", want.year_length, year_length);
          check_field("month_days", want.month_days, month_days);
          check_field("weekday", want.weekday, weekday);
          check_field("ordinal_day", want.ordinal_day, ordinal_day);
          check_field("week_number", want.week_number, week_number);
          check_field("bad_date", want.bad_date, bad_date);
        end
      end
      if (start && !busy) begin
        props_due.push_back(calendar_props(year, month, day));
      end
      if (stall_cycles >= STALL_MAX) begin
        $display("iso_date_properties_unit regression: fail");
        $finish;
      end
    end
  end

  task automatic send_date(logic [13:0] y, logic [3:0] m, logic [4:0] d);
    while (idle_en && $urandom_range(0, 99) < IDLE_PCT) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    year  <= y;
    month <= m;
    day   <= d;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic test_year_limits();
    send_date(14'd0, 4'd1, 5'd1);
    send_date(14'd1, 4'd1, 5'd1);
    send_date(14'd1, 4'd12, 5'd31);
    send_date(14'd9999, 4'd12, 5'd31);
    send_date(14'd10000, 4'd6, 5'd15);
    send_date(14'd16383, 4'd2, 5'd29);
    send_date(14'd2000, 4'd2, 5'd29);
    send_date(14'd1900, 4'd3, 5'd1);
  endtask

  task automatic test_bad_fields();
    send_date(14'd2023, 4'd0, 5'd10);
    send_date(14'd2023, 4'd13, 5'd1);
    send_date(14'd2023, 4'd15, 5'd31);
    send_date(14'd2023, 4'd4, 5'd0);
    send_date(14'd2023, 4'd4, 5'd31);
    send_date(14'd2024, 4'd2, 5'd30);
    send_date(14'd1900, 4'd2, 5'd29);
  endtask

  task automatic test_week_edges();
    send_date(14'd2021, 4'd1, 5'd1);
    send_date(14'd2005, 4'd1, 5'd1);
    send_date(14'd2011, 4'd1, 5'd1);
    send_date(14'd2019, 4'd12, 5'd30);
    send_date(14'd2020, 4'd12, 5'd31);
    send_date(14'd2015, 4'd12, 5'd31);
    send_date(14'd2010, 4'd1, 5'd3);
  endtask

  task automatic test_random_dates();
    int unsigned y;
    int unsigned m;
    int unsigned mlen;
    int unsigned d;
    int unsigned pick;
    int unsigned edge_years[14] = '{1, 2, 3, 99, 100, 101, 399, 400, 401,
                                    1600, 1900, 2000, 9998, 9999};
    for (int n = 0; n < RAND_DATES; n++) begin
      idle_en = !(n >= 400 && n < 700);
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        send_date(14'($urandom), 4'($urandom), 5'($urandom));
      end else begin
        y = (pick < 30) ? edge_years[$urandom_range(0, 13)] : $urandom_range(1, 9999);
        m = (pick < 55) ? ($urandom_range(0, 1) ? MONTH_DEC : MONTH_JAN)
                        : $urandom_range(1, 12);
        mlen = days_in_month(y, m);
        if (pick < 55)
          d = (m == MONTH_JAN) ? $urandom_range(1, 7) : $urandom_range(mlen - 6, mlen);
        else
          d = $urandom_range(1, mlen);
        send_date(14'(y), 4'(m), 5'(d));
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_year_limits();
    test_bad_fields();
    test_week_edges();
    test_random_dates();
    start <= 1'b0;
    while (props_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    if (fail_count == 0)
      $display("iso_date_properties_unit regression: pass");
    else
      $display("iso_date_properties_unit regression: fail");
    $finish;
  end

endmodule
